// File: rtl/core/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MEM_AW        = $clog2(PALETTE_DEPTH);

  localparam int SLOT_W  = 8;
  localparam int COMP_W  = 16;
  localparam int PIXEL_W = 32;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = 34;
  localparam int CFG_W   = 32;
  localparam int CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_RANGE_START = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_RANGE_END   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WHITE_PIXEL = 2'd2;

  typedef struct packed {
    logic              load;
    logic              init;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_sts_t;

endpackage

// File: rtl/core/npcs_datapath.sv
// ----------------------------------------------------------------------------
// npcs_datapath
// Palette memory, distance pipeline and running minimum.
// ----------------------------------------------------------------------------
module npcs_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  npcs_pkg::dp_cmd_t               cmd,
  output npcs_pkg::dp_sts_t               sts,
  input  logic [npcs_pkg::SLOT_W-1:0]     in_entry_slot,
  input  logic [npcs_pkg::COMP_W-1:0]     in_red,
  input  logic [npcs_pkg::COMP_W-1:0]     in_green,
  input  logic [npcs_pkg::COMP_W-1:0]     in_blue,
  input  logic [npcs_pkg::PIXEL_W-1:0]    in_entry_pixel,
  input  logic [npcs_pkg::SLOT_W-1:0]     range_start,
  input  logic [npcs_pkg::PIXEL_W-1:0]    white_pixel,
  output logic [npcs_pkg::SLOT_W-1:0]     best_slot,
  output logic [npcs_pkg::PIXEL_W-1:0]    best_pixel,
  output logic [npcs_pkg::DIST_W-1:0]     best_distance
);

  localparam int ENTRY_W = 3 * npcs_pkg::COMP_W + npcs_pkg::PIXEL_W;

  logic [ENTRY_W-1:0] mem [npcs_pkg::PALETTE_DEPTH];

  // query color
  logic [npcs_pkg::COMP_W-1:0] q_red_r, q_green_r, q_blue_r;

  // stage 1: memory read
  logic                         v1_r;
  logic [npcs_pkg::SLOT_W-1:0]  slot1_r;
  logic [ENTRY_W-1:0]           ent1_r;

  // stage 2: absolute differences
  logic                         v2_r;
  logic [npcs_pkg::SLOT_W-1:0]  slot2_r;
  logic [npcs_pkg::PIXEL_W-1:0] pix2_r;
  logic [npcs_pkg::COMP_W-1:0]  dr2_r, dg2_r, db2_r;

  // stage 3: squares
  logic                         v3_r;
  logic [npcs_pkg::SLOT_W-1:0]  slot3_r;
  logic [npcs_pkg::PIXEL_W-1:0] pix3_r;
  logic [npcs_pkg::SQ_W-1:0]    sr3_r, sg3_r, sb3_r;

  // stage 4: sum
  logic                         v4_r;
  logic [npcs_pkg::SLOT_W-1:0]  slot4_r;
  logic [npcs_pkg::PIXEL_W-1:0] pix4_r;
  logic [npcs_pkg::DIST_W-1:0]  dist4_r;

  // running best
  logic                         found_r;
  logic [npcs_pkg::SLOT_W-1:0]  best_slot_r;
  logic [npcs_pkg::PIXEL_W-1:0] best_pixel_r;
  logic [npcs_pkg::DIST_W-1:0]  best_dist_r;

  logic [npcs_pkg::COMP_W-1:0]  e_red, e_green, e_blue;
  logic [npcs_pkg::PIXEL_W-1:0] e_pixel;
  logic                         take;

  function automatic logic [npcs_pkg::COMP_W-1:0] abs_diff(
    input logic [npcs_pkg::COMP_W-1:0] a,
    input logic [npcs_pkg::COMP_W-1:0] b
  );
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign {e_red, e_green, e_blue, e_pixel} = ent1_r;
  assign take = v4_r && (!found_r || (dist4_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[npcs_pkg::MEM_AW'(in_entry_slot)] <= {in_red, in_green, in_blue, in_entry_pixel};
    end
    if (cmd.rd_en) begin
      ent1_r <= mem[npcs_pkg::MEM_AW'(cmd.rd_slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (cmd.init) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot1_r <= cmd.rd_slot;

    slot2_r <= slot1_r;
    pix2_r  <= e_pixel;
    dr2_r   <= abs_diff(e_red, q_red_r);
    dg2_r   <= abs_diff(e_green, q_green_r);
    db2_r   <= abs_diff(e_blue, q_blue_r);

    slot3_r <= slot2_r;
    pix3_r  <= pix2_r;
    sr3_r   <= dr2_r * dr2_r;
    sg3_r   <= dg2_r * dg2_r;
    sb3_r   <= db2_r * db2_r;

    slot4_r <= slot3_r;
    pix4_r  <= pix3_r;
    dist4_r <= npcs_pkg::DIST_W'(sr3_r) + npcs_pkg::DIST_W'(sg3_r)
             + npcs_pkg::DIST_W'(sb3_r);

    if (cmd.init) begin
      q_red_r      <= in_red;
      q_green_r    <= in_green;
      q_blue_r     <= in_blue;
      best_slot_r  <= range_start;
      best_pixel_r <= white_pixel;
      best_dist_r  <= '0;
    end else if (take) begin
      best_slot_r  <= slot4_r;
      best_pixel_r <= pix4_r;
      best_dist_r  <= dist4_r;
    end
  end

  assign sts.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign best_slot     = best_slot_r;
  assign best_pixel    = best_pixel_r;
  assign best_distance = best_dist_r;

endmodule

// File: rtl/core/npcs_ctrl.sv
// ----------------------------------------------------------------------------
// npcs_ctrl
// Request sequencer: palette loads, slot scan, pipeline drain, result strobe.
// ----------------------------------------------------------------------------
module npcs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_mode,
  input  logic [npcs_pkg::SLOT_W-1:0] in_entry_slot,
  input  logic [npcs_pkg::SLOT_W-1:0] range_start,
  input  logic [npcs_pkg::SLOT_W-1:0] range_end,
  input  npcs_pkg::dp_sts_t           sts,
  output npcs_pkg::dp_cmd_t           cmd,
  output logic                        busy,
  output logic                        out_valid
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [npcs_pkg::SLOT_W-1:0] addr_r, addr_nxt;
  logic [npcs_pkg::SLOT_W-1:0] last_r, last_nxt;
  logic [npcs_pkg::SLOT_W-1:0] last_eff;
  logic                        accept;
  logic                        empty;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    if (int'(range_end) > npcs_pkg::PALETTE_DEPTH - 1) begin
      last_eff = npcs_pkg::SLOT_W'(npcs_pkg::PALETTE_DEPTH - 1);
    end else begin
      last_eff = range_end;
    end
    empty = (range_start > range_end) || (int'(range_start) >= npcs_pkg::PALETTE_DEPTH);
  end

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    last_nxt    = last_r;
    cmd.load    = 1'b0;
    cmd.init    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_slot = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_mode) begin
            cmd.load = int'(in_entry_slot) < npcs_pkg::PALETTE_DEPTH;
          end else begin
            cmd.init = 1'b1;
            addr_nxt = range_start;
            last_nxt = last_eff;
            state_nxt = empty ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (addr_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    last_r <= last_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

// File: rtl/core/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of RGB entries with a nearest-color search by squared distance.
// ----------------------------------------------------------------------------
// A load request (in_mode 0) writes one palette entry and gives no result;
// busy stays low. A query request (in_mode 1) reads one palette slot per
// cycle through the single memory read port, then waits in DRAIN until the
// pipeline is empty; the result strobe out_valid is high in DONE, the last
// state before busy drops. An empty range goes straight to DONE.
// The result is shown for exactly one cycle and the receiver cannot stall it.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while busy is low.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [npcs_pkg::SLOT_W-1:0]  in_entry_slot,
  input  logic [npcs_pkg::COMP_W-1:0]  in_red,
  input  logic [npcs_pkg::COMP_W-1:0]  in_green,
  input  logic [npcs_pkg::COMP_W-1:0]  in_blue,
  input  logic [npcs_pkg::PIXEL_W-1:0] in_entry_pixel,
  output logic                         out_valid,
  output logic [npcs_pkg::SLOT_W-1:0]  out_best_slot,
  output logic [npcs_pkg::PIXEL_W-1:0] out_best_pixel,
  output logic [npcs_pkg::DIST_W-1:0]  out_best_distance,
  input  logic                         cfg_we,
  input  logic [npcs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [npcs_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [npcs_pkg::SLOT_W-1:0]  range_start_r;
  logic [npcs_pkg::SLOT_W-1:0]  range_end_r;
  logic [npcs_pkg::PIXEL_W-1:0] white_pixel_r;

  npcs_pkg::dp_cmd_t dp_cmd;
  npcs_pkg::dp_sts_t dp_sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_start_r <= '0;
      range_end_r   <= '1;
      white_pixel_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        npcs_pkg::CFG_RANGE_START: range_start_r <= cfg_wdata[npcs_pkg::SLOT_W-1:0];
        npcs_pkg::CFG_RANGE_END:   range_end_r   <= cfg_wdata[npcs_pkg::SLOT_W-1:0];
        npcs_pkg::CFG_WHITE_PIXEL: white_pixel_r <= cfg_wdata[npcs_pkg::PIXEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  npcs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_mode       (in_mode),
    .in_entry_slot (in_entry_slot),
    .range_start   (range_start_r),
    .range_end     (range_end_r),
    .sts           (dp_sts),
    .cmd           (dp_cmd),
    .busy          (busy),
    .out_valid     (out_valid)
  );

  npcs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .in_entry_slot  (in_entry_slot),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_entry_pixel (in_entry_pixel),
    .range_start    (range_start_r),
    .white_pixel    (white_pixel_r),
    .best_slot      (out_best_slot),
    .best_pixel     (out_best_pixel),
    .best_distance  (out_best_distance)
  );

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode |=> busy)
    else $error("query request did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_mode |=> !busy && !out_valid)
    else $error("load request started a search");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (range_start_r > range_end_r) |->
      out_best_distance == '0 && out_best_pixel == white_pixel_r &&
      out_best_slot == range_start_r)
    else $error("empty range result mismatch");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_palette_color_search.
// ----------------------------------------------------------------------------
// Loads palette entries and issues nearest-color queries over many search
// ranges. These include full, single-slot, empty and short ranges, and the
// pixel value for an empty range is varied too. A scoreboard keeps its own
// copy of the palette and the registers. For every accepted query it
// computes the expected slot, pixel and squared distance. Each strobed
// result is checked against the oldest pending answer. Queries only touch
// slots that have been loaded. Register writes happen with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import npcs_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int ITEMS_PER_RUN = 600;

  typedef struct packed {
    bit [SLOT_W-1:0]  slot;
    bit [PIXEL_W-1:0] pixel;
    bit [DIST_W-1:0]  dist_sq;
  } color_match_t;

  class nearest_color_checker;
    bit [COMP_W-1:0]  pal_red   [PALETTE_DEPTH];
    bit [COMP_W-1:0]  pal_green [PALETTE_DEPTH];
    bit [COMP_W-1:0]  pal_blue  [PALETTE_DEPTH];
    bit [PIXEL_W-1:0] pal_pixel [PALETTE_DEPTH];
    bit [SLOT_W-1:0]  range_lo  = '0;
    bit [SLOT_W-1:0]  range_hi  = '1;
    bit [PIXEL_W-1:0] white_pix = '0;
    color_match_t     pending_matches[$];
    int               mismatches = 0;

    function void write_reg(bit [CFG_IW-1:0] idx, bit [CFG_W-1:0] data);
      case (idx)
        CFG_RANGE_START: range_lo  = data[SLOT_W-1:0];
        CFG_RANGE_END:   range_hi  = data[SLOT_W-1:0];
        CFG_WHITE_PIXEL: white_pix = data[PIXEL_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [DIST_W-1:0] comp_sq(bit [COMP_W-1:0] a, bit [COMP_W-1:0] b);
      bit [COMP_W-1:0] d;
      bit [SQ_W-1:0]   sq;
      d  = (a > b) ? a - b : b - a;
      sq = d * d;
      return DIST_W'(sq);
    endfunction

    function void note_request(bit mode, bit [SLOT_W-1:0] slot, bit [COMP_W-1:0] r,
                               bit [COMP_W-1:0] g, bit [COMP_W-1:0] b,
                               bit [PIXEL_W-1:0] pix);
      color_match_t    best;
      bit              found;
      bit [DIST_W-1:0] d;
      if (mode == MODE_LOAD) begin
        pal_red[slot]   = r;
        pal_green[slot] = g;
        pal_blue[slot]  = b;
        pal_pixel[slot] = pix;
        return;
      end
      found        = 1'b0;
      best.slot    = range_lo;
      best.pixel   = white_pix;
      best.dist_sq = '0;
      for (int s = range_lo; s <= range_hi; s++) begin
        d = comp_sq(pal_red[s], r) + comp_sq(pal_green[s], g) + comp_sq(pal_blue[s], b);
        // strict less-than: earliest slot wins a tie
        if (!found || d < best.dist_sq) begin
          found        = 1'b1;
          best.slot    = SLOT_W'(s);
          best.pixel   = pal_pixel[s];
          best.dist_sq = d;
        end
      end
      pending_matches.push_back(best);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [SLOT_W-1:0] slot, logic [PIXEL_W-1:0] pix,
                      logic [DIST_W-1:0] dist_sq);
      color_match_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("result with no pending query: slot %0d", slot));
        return;
      end
      want = pending_matches.pop_front();
      if (slot !== want.slot)
        report_mismatch($sformatf("best_slot %0d, expected %0d", slot, want.slot));
      if (pix !== want.pixel)
        report_mismatch($sformatf("best_pixel %h, expected %h", pix, want.pixel));
      if (dist_sq !== want.dist_sq)
        report_mismatch($sformatf("best_distance %0d, expected %0d", dist_sq,
                                  want.dist_sq));
    endtask

    function int pending();
      return pending_matches.size();
    endfunction
  endclass

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                in_mode        = MODE_LOAD;
  logic [SLOT_W-1:0]   in_entry_slot  = '0;
  logic [COMP_W-1:0]   in_red         = '0;
  logic [COMP_W-1:0]   in_green       = '0;
  logic [COMP_W-1:0]   in_blue        = '0;
  logic [PIXEL_W-1:0]  in_entry_pixel = '0;
  logic                out_valid;
  logic [SLOT_W-1:0]   out_best_slot;
  logic [PIXEL_W-1:0]  out_best_pixel;
  logic [DIST_W-1:0]   out_best_distance;
  logic                cfg_we         = 1'b0;
  logic [CFG_IW-1:0]   cfg_index      = '0;
  logic [CFG_W-1:0]    cfg_wdata      = '0;

  nearest_color_checker chk = new();

  int idle_pct;
  int items_sent;
  int cycle_count;
  bit               slot_loaded [PALETTE_DEPTH];
  bit [COMP_W-1:0]  loaded_red   [PALETTE_DEPTH];
  bit [COMP_W-1:0]  loaded_green [PALETTE_DEPTH];
  bit [COMP_W-1:0]  loaded_blue  [PALETTE_DEPTH];

  nearest_palette_color_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_entry_slot     (in_entry_slot),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_entry_pixel    (in_entry_pixel),
    .out_valid         (out_valid),
    .out_best_slot     (out_best_slot),
    .out_best_pixel    (out_best_pixel),
    .out_best_distance (out_best_distance),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        chk.check_result(out_best_slot, out_best_pixel, out_best_distance);
      if (cfg_we)
        chk.write_reg(cfg_index, cfg_wdata);
      if (start && !busy)
        chk.note_request(in_mode, in_entry_slot, in_red, in_green, in_blue, in_entry_pixel);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // extremes or a coarse grid half the time, so that ties and exact hits are common
  function automatic bit [COMP_W-1:0] pick_comp();
    case ($urandom_range(3))
      0:       return {COMP_W{$urandom_range(1) == 1}};
      1:       return COMP_W'($urandom_range(3)) << (COMP_W - 2);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic bit [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  task automatic send_request(logic mode, logic [SLOT_W-1:0] slot, logic [COMP_W-1:0] r,
                              logic [COMP_W-1:0] g, logic [COMP_W-1:0] b,
                              logic [PIXEL_W-1:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_mode        <= mode;
    in_entry_slot  <= slot;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_entry_pixel <= pix;
    do @(posedge clk); while (busy);
    items_sent++;
    if (mode == MODE_LOAD) begin
      slot_loaded[slot]  = 1'b1;
      loaded_red[slot]   = r;
      loaded_green[slot] = g;
      loaded_blue[slot]  = b;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    // a trailing load may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(bit [SLOT_W-1:0] lo, bit [SLOT_W-1:0] hi,
                           bit [PIXEL_W-1:0] white);
    bit [CFG_W-1:0] junk;
    drain();
    // upper data bits are don't-care for the 8-bit range registers
    junk = $urandom;
    write_reg(CFG_RANGE_START, {junk[CFG_W-1:SLOT_W], lo});
    junk = $urandom;
    write_reg(CFG_RANGE_END, {junk[CFG_W-1:SLOT_W], hi});
    write_reg(CFG_WHITE_PIXEL, white);
  endtask

  initial begin
    bit [SLOT_W-1:0]  lo, hi, ref_slot;
    bit [COMP_W-1:0]  r, g, b;
    bit [PIXEL_W-1:0] white;

    idle_pct = 23;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, tie on first minimum, exact hit, max distance, empty
    configure(8'd0, 8'd3, '1);
    send_request(MODE_LOAD, 8'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    send_request(MODE_LOAD, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_LOAD, 8'd2, 16'h0000, 16'h0000, 16'h0000, 32'hA5A5_A5A5);
    send_request(MODE_LOAD, 8'd3, 16'h8000, 16'h7FFF, 16'h0001, 32'h5A5A_5A5A);
    send_request(MODE_LOAD, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h1234_5678);
    send_request(MODE_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 32'h0);
    send_request(MODE_QUERY, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_QUERY, 8'h5A, 16'h8000, 16'h7FFF, 16'h0001, 32'h0);
    send_request(MODE_QUERY, 8'hA5, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h0);
    send_request(MODE_QUERY, SLOT_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
                 COMP_W'($urandom), $urandom);
    configure(8'd1, 8'd1, '1);
    send_request(MODE_QUERY, SLOT_W'($urandom), 16'h0000, 16'h0000, 16'h0000, $urandom);
    configure(8'd255, 8'd255, $urandom);
    send_request(MODE_QUERY, SLOT_W'($urandom), 16'h0000, 16'hFFFF, 16'h0000, $urandom);
    configure(8'd3, 8'd0, '0);
    send_request(MODE_QUERY, SLOT_W'($urandom), 16'h1234, 16'h5678, 16'h9ABC, $urandom);
    configure(8'd255, 8'd0, $urandom);
    send_request(MODE_QUERY, SLOT_W'($urandom), COMP_W'($urandom), COMP_W'($urandom),
                 COMP_W'($urandom), $urandom);
    configure(8'd0, 8'd0, $urandom);
    send_request(MODE_QUERY, SLOT_W'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom);

    for (int run = 0; run < 3; run++) begin
      idle_pct = (run == 0) ? 23 : (run == 1) ? 65 : 0;
      while (items_sent < (run + 1) * ITEMS_PER_RUN) begin
        case ($urandom_range(9))
          0: begin
            lo = 8'd0;
            hi = 8'd255;
          end
          1: begin
            lo = SLOT_W'($urandom_range(255, 1));
            hi = SLOT_W'($urandom_range(lo - 1, 0));
          end
          2: begin
            lo = SLOT_W'($urandom);
            hi = lo;
          end
          3: begin
            lo = 8'd0;
            hi = SLOT_W'($urandom_range(31));
          end
          4: begin
            lo = SLOT_W'($urandom_range(255, 224));
            hi = 8'd255;
          end
          default: begin
            lo = SLOT_W'($urandom);
            hi = (lo > 8'd240) ? 8'd255 : lo + SLOT_W'($urandom_range(15));
          end
        endcase
        configure(lo, hi, pick_pixel());

        // every slot in range must hold a loaded entry before a query
        for (int s = lo; s <= hi; s++)
          if (!slot_loaded[s])
            send_request(MODE_LOAD, SLOT_W'(s), pick_comp(), pick_comp(), pick_comp(),
                         pick_pixel());

        repeat ($urandom_range(90, 30)) begin
          ref_slot = SLOT_W'($urandom_range(hi, lo));
          if ($urandom_range(99) < 55) begin
            case ($urandom_range(3))
              0: begin
                r = COMP_W'($urandom);
                g = COMP_W'($urandom);
                b = COMP_W'($urandom);
              end
              1: begin
                r = loaded_red[ref_slot];
                g = loaded_green[ref_slot];
                b = loaded_blue[ref_slot];
              end
              2: begin
                r = pick_comp();
                g = pick_comp();
                b = pick_comp();
              end
              default: begin
                r = loaded_red[ref_slot] + COMP_W'($urandom_range(3));
                g = loaded_green[ref_slot] - COMP_W'($urandom_range(3));
                b = loaded_blue[ref_slot] + COMP_W'($urandom_range(3));
              end
            endcase
            send_request(MODE_QUERY, SLOT_W'($urandom), r, g, b, $urandom);
          end else begin
            if ($urandom_range(1) == 1)
              ref_slot = SLOT_W'($urandom);
            send_request(MODE_LOAD, ref_slot, pick_comp(), pick_comp(), pick_comp(),
                         pick_pixel());
          end
        end
      end
    end

    drain();
    if (chk.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: nearest_palette_color_search.f
rtl/core/npcs_pkg.sv
rtl/core/npcs_datapath.sv
rtl/core/npcs_ctrl.sv
rtl/core/nearest_palette_color_search.sv
test/tb_top.sv
